/* rtl/core/ccsm_pkg.sv */
// Shared constants and types for the cubic curve sampler with circular mask.
// Holds field widths, fixed-point format and the default derived widths.
// No dependencies.
package ccsm_pkg;

  localparam int KW   = 10;  // sample index width
  localparam int CW   = 10;  // coordinate width
  localparam int RADW = 9;   // radius register width
  localparam int PIXW = 12;  // output pixel width
  localparam int FRAC = 16;  // fraction bits of the fixed-point format

  // A difference beyond this exponent is far outside any legal circle.
  localparam int FAR_SH = CW + FRAC;

  localparam logic [RADW-1:0] RADIUS_RST = RADW'(60);

  localparam int SAMPLES_DEF = 1000;

  localparam longint KMAX = (longint'(1) << KW) - 1;

  // Widths for the default sample count; the top level recomputes these for its own.
  localparam longint TMAX_DEF  = (KMAX << FRAC) / SAMPLES_DEF;
  localparam longint T2MAX_DEF = (TMAX_DEF * TMAX_DEF) >> FRAC;
  localparam longint T3MAX_DEF = (T2MAX_DEF * TMAX_DEF) >> FRAC;
  localparam longint HBND_DEF  = 27 * T3MAX_DEF + 45 * T2MAX_DEF + 18 * TMAX_DEF
                                 + (longint'(2) << FRAC);

  localparam int TW_RAW_DEF  = $clog2(TMAX_DEF + 1);
  localparam int T2W_RAW_DEF = $clog2(T2MAX_DEF + 1);
  localparam int T3W_RAW_DEF = $clog2(T3MAX_DEF + 1);
  localparam int TW_DEF  = (TW_RAW_DEF  < 1) ? 1 : TW_RAW_DEF;
  localparam int T2W_DEF = (T2W_RAW_DEF < 1) ? 1 : T2W_RAW_DEF;
  localparam int T3W_DEF = (T3W_RAW_DEF < 1) ? 1 : T3W_RAW_DEF;
  localparam int HW_DEF  = $clog2(HBND_DEF + 1) + 1;
  localparam int WW_DEF  = HW_DEF - 1;
  localparam int XW_DEF  = WW_DEF + 12;
  localparam int DXW_DEF = ((XW_DEF > FAR_SH + 1) ? XW_DEF : FAR_SH + 1) + 1;

  localparam int SHIFT_DEF = KW + FRAC + $clog2(SAMPLES_DEF);
  localparam int RECIP_DEF = int'(((longint'(1) << SHIFT_DEF) + SAMPLES_DEF - 1)
                                  / SAMPLES_DEF);

  // Control points and circle center; they travel with each beat.
  typedef struct packed {
    logic [3:0][CW-1:0] px;
    logic [3:0][CW-1:0] py;
    logic [CW-1:0]      cx;
    logic [CW-1:0]      cy;
  } geom_t;

endpackage

/* rtl/core/ccsm_basis.sv */
// Basis stages: parameter t from the sample index, its powers, and the four
// Lagrange weights in signed Q16. Depends on ccsm_pkg.
module ccsm_basis #(
  parameter int TW    = ccsm_pkg::TW_DEF,
  parameter int T2W   = ccsm_pkg::T2W_DEF,
  parameter int T3W   = ccsm_pkg::T3W_DEF,
  parameter int HW    = ccsm_pkg::HW_DEF,
  parameter int SHIFT = ccsm_pkg::SHIFT_DEF,
  parameter int RECIP = ccsm_pkg::RECIP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ccsm_pkg::KW-1:0]       sample_index,
  input  ccsm_pkg::geom_t               geom,
  output logic                          w_valid,
  output logic [3:0][HW-2:0]            w,
  output ccsm_pkg::geom_t               w_geom
);

  localparam int WW  = HW - 1;
  localparam int RW  = ccsm_pkg::KW + ccsm_pkg::FRAC + 1;
  localparam int PAW = ccsm_pkg::KW + RW;
  localparam int P2W = (2 * TW > ccsm_pkg::FRAC + T2W) ? 2 * TW : ccsm_pkg::FRAC + T2W;
  localparam int P3W = (T2W + TW > ccsm_pkg::FRAC + T3W) ? T2W + TW
                                                          : ccsm_pkg::FRAC + T3W;
  localparam int TOFF = SHIFT - ccsm_pkg::FRAC;

  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
  localparam logic [HW-1:0] TWO_Q   = HW'(longint'(2) << ccsm_pkg::FRAC);

  logic                   a_valid_r, b_valid_r, c_valid_r, d_valid_r;
  logic [TW-1:0]          a_t_r, b_t_r, c_t_r;
  logic [T2W-1:0]         b_t2_r, c_t2_r;
  logic [T3W-1:0]         c_t3_r;
  logic [3:0][WW-1:0]     d_w_r;
  ccsm_pkg::geom_t        a_geom_r, b_geom_r, c_geom_r, d_geom_r;

  logic [PAW-1:0]         prod_a;
  logic [P2W-1:0]         prod_b;
  logic [P3W-1:0]         prod_c;
  logic [TW-1:0]          a_t_nxt;
  logic [T2W-1:0]         b_t2_nxt;
  logic [T3W-1:0]         c_t3_nxt;
  logic [HW-1:0]          tq, t2q, t3q;
  logic [3:0][HW-1:0]     h;
  logic [3:0][WW-1:0]     d_w_nxt;

  always_comb begin
    // Division by the sample count is a multiply by a rounded-up reciprocal,
    // exact for every index the input can carry.
    prod_a   = PAW'(sample_index) * PAW'(RECIP_C);
    a_t_nxt  = prod_a[TOFF +: TW];
    prod_b   = P2W'(a_t_r) * P2W'(a_t_r);
    b_t2_nxt = prod_b[ccsm_pkg::FRAC +: T2W];
    prod_c   = P3W'(b_t2_r) * P3W'(b_t_r);
    c_t3_nxt = prod_c[ccsm_pkg::FRAC +: T3W];

    tq  = HW'(c_t_r);
    t2q = HW'(c_t2_r);
    t3q = HW'(c_t3_r);
    // Doubled weights are exact; two's complement wraps harmlessly in HW bits.
    h[0] = t2q * HW'(18) - t3q * HW'(9) - tq * HW'(11) + TWO_Q;
    h[1] = t3q * HW'(27) - t2q * HW'(45) + tq * HW'(18);
    h[2] = t2q * HW'(36) - t3q * HW'(27) - tq * HW'(9);
    h[3] = t3q * HW'(9) - t2q * HW'(9) + tq * HW'(2);
    for (int i = 0; i < 4; i++) begin
      d_w_nxt[i] = h[i][HW-1:1];  // floor of half
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_t_r    <= a_t_nxt;
    a_geom_r <= geom;
    b_t_r    <= a_t_r;
    b_t2_r   <= b_t2_nxt;
    b_geom_r <= a_geom_r;
    c_t_r    <= b_t_r;
    c_t2_r   <= b_t2_r;
    c_t3_r   <= c_t3_nxt;
    c_geom_r <= b_geom_r;
    d_w_r    <= d_w_nxt;
    d_geom_r <= c_geom_r;
  end

  assign w_valid = d_valid_r;
  assign w       = d_w_r;
  assign w_geom  = d_geom_r;

endmodule

/* rtl/core/ccsm_blend.sv */
// Blend stages: weighted sums of the control points and the offsets of the
// resulting point from the circle center, all in signed Q16. Depends on ccsm_pkg.
module ccsm_blend #(
  parameter int WW  = ccsm_pkg::WW_DEF,
  parameter int XW  = ccsm_pkg::XW_DEF,
  parameter int DXW = ccsm_pkg::DXW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 w_valid,
  input  logic [3:0][WW-1:0]   w,
  input  ccsm_pkg::geom_t      geom,
  output logic                 sum_valid,
  output logic [XW-1:0]        sum_x,
  output logic [XW-1:0]        sum_y,
  output logic [DXW-1:0]       dx,
  output logic [DXW-1:0]       dy
);

  localparam int PW = WW + ccsm_pkg::CW;

  logic                        e_valid_r, f_valid_r;
  logic [3:0][PW-1:0]          e_px_r, e_py_r, e_px_nxt, e_py_nxt;
  logic [ccsm_pkg::CW-1:0]     e_cx_r, e_cy_r;
  logic [XW-1:0]               f_x_r, f_y_r, f_x_nxt, f_y_nxt;
  logic [DXW-1:0]              f_dx_r, f_dy_r, f_dx_nxt, f_dy_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e_px_nxt[i] = PW'($signed(w[i])) * PW'($signed({1'b0, geom.px[i]}));
      e_py_nxt[i] = PW'($signed(w[i])) * PW'($signed({1'b0, geom.py[i]}));
    end
    f_x_nxt = '0;
    f_y_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      f_x_nxt = f_x_nxt + XW'($signed(e_px_r[i]));
      f_y_nxt = f_y_nxt + XW'($signed(e_py_r[i]));
    end
    f_dx_nxt = DXW'($signed(f_x_nxt)) - DXW'({e_cx_r, {ccsm_pkg::FRAC{1'b0}}});
    f_dy_nxt = DXW'($signed(f_y_nxt)) - DXW'({e_cy_r, {ccsm_pkg::FRAC{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      e_valid_r <= w_valid;
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    e_px_r <= e_px_nxt;
    e_py_r <= e_py_nxt;
    e_cx_r <= geom.cx;
    e_cy_r <= geom.cy;
    f_x_r  <= f_x_nxt;
    f_y_r  <= f_y_nxt;
    f_dx_r <= f_dx_nxt;
    f_dy_r <= f_dy_nxt;
  end

  assign sum_valid = f_valid_r;
  assign sum_x     = f_x_r;
  assign sum_y     = f_y_r;
  assign dx        = f_dx_r;
  assign dy        = f_dy_r;

endmodule

/* rtl/core/ccsm_mask.sv */
// Mask stages: squared distance against the squared radius, coordinate
// truncation and saturation, and the result register. Depends on ccsm_pkg.
module ccsm_mask #(
  parameter int XW  = ccsm_pkg::XW_DEF,
  parameter int DXW = ccsm_pkg::DXW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ccsm_pkg::RADW-1:0]   radius,
  input  logic                        sum_valid,
  input  logic [XW-1:0]               sum_x,
  input  logic [XW-1:0]               sum_y,
  input  logic [DXW-1:0]              dx,
  input  logic [DXW-1:0]              dy,
  output logic                        out_valid,
  output logic [ccsm_pkg::PIXW-1:0]   pixel_x,
  output logic [ccsm_pkg::PIXW-1:0]   pixel_y,
  output logic                        inside_res
);

  localparam int AXW = ccsm_pkg::FAR_SH + 1;
  localparam int SQW = 2 * AXW;
  localparam int DW  = SQW + 1;
  localparam int QW  = XW - ccsm_pkg::FRAC;
  localparam int RSW = 2 * ccsm_pkg::RADW;

  localparam logic signed [DXW-1:0] FAR_POS = DXW'(longint'(1) << ccsm_pkg::FAR_SH);
  localparam logic signed [DXW-1:0] FAR_NEG = -FAR_POS;
  localparam logic signed [QW-1:0]  Q_HI = QW'((1 << (ccsm_pkg::PIXW - 1)) - 1);
  localparam logic signed [QW-1:0]  Q_LO = -Q_HI - QW'(1);
  localparam logic [ccsm_pkg::PIXW-1:0] PIX_HI = {1'b0, {(ccsm_pkg::PIXW-1){1'b1}}};
  localparam logic [ccsm_pkg::PIXW-1:0] PIX_LO = {1'b1, {(ccsm_pkg::PIXW-1){1'b0}}};

  // Truncation toward zero of a Q16 value, then clamp to the pixel range.
  function automatic logic [ccsm_pkg::PIXW-1:0] trunc_sat(input logic [XW-1:0] v);
    logic [QW-1:0] q;
    q = v[XW-1:ccsm_pkg::FRAC];
    if (v[XW-1] && (v[ccsm_pkg::FRAC-1:0] != '0)) begin
      q = q + QW'(1);
    end
    if ($signed(q) > Q_HI) begin
      return PIX_HI;
    end else if ($signed(q) < Q_LO) begin
      return PIX_LO;
    end
    return q[ccsm_pkg::PIXW-1:0];
  endfunction

  logic                          g_valid_r, g_far_r, g_far_nxt;
  logic [SQW-1:0]                g_sqx_r, g_sqy_r, g_sqx_nxt, g_sqy_nxt;
  logic [ccsm_pkg::PIXW-1:0]     g_pix_x_r, g_pix_y_r;
  logic [DXW-1:0]                abs_x, abs_y;
  logic [AXW-1:0]                ax, ay;
  logic [DW-1:0]                 dist_sq, rad_sq_q;
  logic [RSW-1:0]                rad_sq;
  logic                          outside, in_circ;
  logic                          out_valid_r, out_valid_nxt, out_inside_r;
  logic [ccsm_pkg::PIXW-1:0]     out_pix_x_r, out_pix_y_r;

  always_comb begin
    g_far_nxt = ($signed(dx) > FAR_POS) || ($signed(dx) < FAR_NEG) ||
                ($signed(dy) > FAR_POS) || ($signed(dy) < FAR_NEG);
    abs_x = dx[DXW-1] ? (-dx) : dx;
    abs_y = dy[DXW-1] ? (-dy) : dy;
    // Only meaningful when not far; the far flag overrides the squares.
    ax = abs_x[AXW-1:0];
    ay = abs_y[AXW-1:0];
    g_sqx_nxt = SQW'(ax) * SQW'(ax);
    g_sqy_nxt = SQW'(ay) * SQW'(ay);

    dist_sq  = DW'(g_sqx_r) + DW'(g_sqy_r);
    rad_sq   = RSW'(radius) * RSW'(radius);
    rad_sq_q = DW'({rad_sq, {(2 * ccsm_pkg::FRAC){1'b0}}});
    outside  = g_far_r || (dist_sq > rad_sq_q);
    in_circ  = !g_far_r && (dist_sq < rad_sq_q);
    // A point exactly on the circle produces no beat.
    out_valid_nxt = g_valid_r && (outside || in_circ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      g_valid_r   <= sum_valid;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_far_r      <= g_far_nxt;
    g_sqx_r      <= g_sqx_nxt;
    g_sqy_r      <= g_sqy_nxt;
    g_pix_x_r    <= trunc_sat(sum_x);
    g_pix_y_r    <= trunc_sat(sum_y);
    out_inside_r <= in_circ;
    out_pix_x_r  <= g_pix_x_r;
    out_pix_y_r  <= g_pix_y_r;
  end

  assign out_valid  = out_valid_r;
  assign pixel_x    = out_pix_x_r;
  assign pixel_y    = out_pix_y_r;
  assign inside_res = out_inside_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inside_r) |-> $past(!g_far_r))
    else $error("inside result from a point flagged far from the center");

endmodule

/* rtl/core/cubic_curve_sample_circle_mask.sv */
// An accepted item moves through the basis, blend and mask stage registers to its result beat.
// Throughput: one item per cycle; busy is always low since the eight-stage
// pipeline never stalls and the receiver takes every beat.
// Points exactly on the circle produce no beat. Synchronous active-low reset
// clears all stage valid bits and sets the radius register to 60.
// Top level of the cubic curve sampler; depends on ccsm_pkg, ccsm_basis,
// ccsm_blend and ccsm_mask.
module cubic_curve_sample_circle_mask #(
  parameter int SAMPLES = ccsm_pkg::SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ccsm_pkg::KW-1:0]     in_sample_index,
  input  logic [ccsm_pkg::CW-1:0]     in_p0_x,
  input  logic [ccsm_pkg::CW-1:0]     in_p0_y,
  input  logic [ccsm_pkg::CW-1:0]     in_p1_x,
  input  logic [ccsm_pkg::CW-1:0]     in_p1_y,
  input  logic [ccsm_pkg::CW-1:0]     in_p2_x,
  input  logic [ccsm_pkg::CW-1:0]     in_p2_y,
  input  logic [ccsm_pkg::CW-1:0]     in_p3_x,
  input  logic [ccsm_pkg::CW-1:0]     in_p3_y,
  input  logic [ccsm_pkg::CW-1:0]     in_center_x,
  input  logic [ccsm_pkg::CW-1:0]     in_center_y,
  input  logic                        cfg_we,
  input  logic [ccsm_pkg::RADW-1:0]   cfg_wdata,
  output logic                        out_valid,
  output logic [ccsm_pkg::PIXW-1:0]   out_pixel_x,
  output logic [ccsm_pkg::PIXW-1:0]   out_pixel_y,
  output logic                        out_inside_res
);

  localparam longint TMAX  = (ccsm_pkg::KMAX << ccsm_pkg::FRAC) / SAMPLES;
  localparam longint T2MAX = (TMAX * TMAX) >> ccsm_pkg::FRAC;
  localparam longint T3MAX = (T2MAX * TMAX) >> ccsm_pkg::FRAC;
  localparam longint HBND  = 27 * T3MAX + 45 * T2MAX + 18 * TMAX
                             + (longint'(2) << ccsm_pkg::FRAC);
  localparam int TW_RAW  = $clog2(TMAX + 1);
  localparam int T2W_RAW = $clog2(T2MAX + 1);
  localparam int T3W_RAW = $clog2(T3MAX + 1);
  localparam int TW  = (TW_RAW  < 1) ? 1 : TW_RAW;
  localparam int T2W = (T2W_RAW < 1) ? 1 : T2W_RAW;
  localparam int T3W = (T3W_RAW < 1) ? 1 : T3W_RAW;
  localparam int HW  = $clog2(HBND + 1) + 1;
  localparam int WW  = HW - 1;
  localparam int XW  = WW + 12;
  localparam int DXW = ((XW > ccsm_pkg::FAR_SH + 1) ? XW : ccsm_pkg::FAR_SH + 1) + 1;
  localparam int SHIFT = ccsm_pkg::KW + ccsm_pkg::FRAC + $clog2(SAMPLES);
  localparam int RECIP = int'(((longint'(1) << SHIFT) + SAMPLES - 1) / SAMPLES);

  localparam int LAT = 8;
  localparam logic signed [ccsm_pkg::PIXW-1:0] IN_LO = -ccsm_pkg::PIXW'(512);
  localparam logic signed [ccsm_pkg::PIXW-1:0] IN_HI = ccsm_pkg::PIXW'(1535);

  logic [ccsm_pkg::RADW-1:0] radius_r, radius_nxt;
  logic                      in_accept;
  ccsm_pkg::geom_t           geom;

  logic                      w_valid;
  logic [3:0][WW-1:0]        w;
  ccsm_pkg::geom_t           w_geom;
  logic                      sum_valid;
  logic [XW-1:0]             sum_x, sum_y;
  logic [DXW-1:0]            dx, dy;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  always_comb begin
    radius_nxt = cfg_we ? cfg_wdata : radius_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= ccsm_pkg::RADIUS_RST;
    end else begin
      radius_r <= radius_nxt;
    end
  end

  always_comb begin
    geom.px[0] = in_p0_x;
    geom.py[0] = in_p0_y;
    geom.px[1] = in_p1_x;
    geom.py[1] = in_p1_y;
    geom.px[2] = in_p2_x;
    geom.py[2] = in_p2_y;
    geom.px[3] = in_p3_x;
    geom.py[3] = in_p3_y;
    geom.cx    = in_center_x;
    geom.cy    = in_center_y;
  end

  ccsm_basis #(
    .TW    (TW),
    .T2W   (T2W),
    .T3W   (T3W),
    .HW    (HW),
    .SHIFT (SHIFT),
    .RECIP (RECIP)
  ) u_basis (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_accept),
    .sample_index (in_sample_index),
    .geom         (geom),
    .w_valid      (w_valid),
    .w            (w),
    .w_geom       (w_geom)
  );

  ccsm_blend #(
    .WW  (WW),
    .XW  (XW),
    .DXW (DXW)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_valid   (w_valid),
    .w         (w),
    .geom      (w_geom),
    .sum_valid (sum_valid),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .dx        (dx),
    .dy        (dy)
  );

  ccsm_mask #(
    .XW  (XW),
    .DXW (DXW)
  ) u_mask (
    .clk        (clk),
    .rst_n      (rst_n),
    .radius     (radius_r),
    .sum_valid  (sum_valid),
    .sum_x      (sum_x),
    .sum_y      (sum_y),
    .dx         (dx),
    .dy         (dy),
    .out_valid  (out_valid),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .inside_res (out_inside_res)
  );

  // Every result beat traces back to an accepted item a fixed latency earlier.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LAT))
    else $error("result beat without a matching accepted item");

  // A point inside the circle lies within one radius of a legal center.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |->
      ($signed(out_pixel_x) >= IN_LO && $signed(out_pixel_x) <= IN_HI))
    else $error("inside beat with x outside the reachable range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |->
      ($signed(out_pixel_y) >= IN_LO && $signed(out_pixel_y) <= IN_HI))
    else $error("inside beat with y outside the reachable range");

endmodule

/* tb/cubic_curve_sample_circle_mask_tb.sv */
// Testbench for the cubic curve sampler with circular mask: a self-checking bench with its
// own fixed-point curve predictor and a scoreboard of expected pixel beats.
// Depends on ccsm_pkg and the cubic_curve_sample_circle_mask top level.
`timescale 1ns / 1ps

module cubic_curve_sample_circle_mask_tb;

  localparam int  LATENCY     = 8;
  localparam int  SETTLE      = LATENCY + 4;
  localparam int  STALL_LIMIT = 2000;
  localparam int  COORD_MAX   = (1 << ccsm_pkg::CW) - 1;
  localparam int  PHASE_ITEMS = 250;
  localparam int  NUM_PHASES  = 6;

  typedef struct packed {
    logic [ccsm_pkg::KW-1:0] k;
    ccsm_pkg::geom_t         g;
  } curve_item_t;

  typedef struct {
    logic [ccsm_pkg::PIXW-1:0] x;
    logic [ccsm_pkg::PIXW-1:0] y;
    logic                      in_circle;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [ccsm_pkg::KW-1:0]   in_sample_index = '0;
  logic [ccsm_pkg::CW-1:0]   in_p0_x = '0;
  logic [ccsm_pkg::CW-1:0]   in_p0_y = '0;
  logic [ccsm_pkg::CW-1:0]   in_p1_x = '0;
  logic [ccsm_pkg::CW-1:0]   in_p1_y = '0;
  logic [ccsm_pkg::CW-1:0]   in_p2_x = '0;
  logic [ccsm_pkg::CW-1:0]   in_p2_y = '0;
  logic [ccsm_pkg::CW-1:0]   in_p3_x = '0;
  logic [ccsm_pkg::CW-1:0]   in_p3_y = '0;
  logic [ccsm_pkg::CW-1:0]   in_center_x = '0;
  logic [ccsm_pkg::CW-1:0]   in_center_y = '0;
  logic                      cfg_we = 1'b0;
  logic [ccsm_pkg::RADW-1:0] cfg_wdata = '0;
  logic                      out_valid;
  logic [ccsm_pkg::PIXW-1:0] out_pixel_x;
  logic [ccsm_pkg::PIXW-1:0] out_pixel_y;
  logic                      out_inside_res;

  cubic_curve_sample_circle_mask uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_index(in_sample_index),
    .in_p0_x        (in_p0_x),
    .in_p0_y        (in_p0_y),
    .in_p1_x        (in_p1_x),
    .in_p1_y        (in_p1_y),
    .in_p2_x        (in_p2_x),
    .in_p2_y        (in_p2_y),
    .in_p3_x        (in_p3_x),
    .in_p3_y        (in_p3_y),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_inside_res (out_inside_res)
  );

  // Curve point in signed Q16 for sample k, built from the Lagrange weights at
  // t = 0, 1/3, 2/3 and 1. The doubled weights are exact; halving floors.
  function automatic void curve_point(input logic [ccsm_pkg::KW-1:0] k,
                                      input ccsm_pkg::geom_t g,
                                      output longint xq, output longint yq);
    longint t, t2, t3;
    longint w[4];
    int i;
    t  = (longint'(k) << ccsm_pkg::FRAC) / ccsm_pkg::SAMPLES_DEF;
    t2 = (t * t) >> ccsm_pkg::FRAC;
    t3 = (t2 * t) >> ccsm_pkg::FRAC;
    w[0] = (-9 * t3 + 18 * t2 - 11 * t + (longint'(2) << ccsm_pkg::FRAC)) >>> 1;
    w[1] = (27 * t3 - 45 * t2 + 18 * t) >>> 1;
    w[2] = (-27 * t3 + 36 * t2 - 9 * t) >>> 1;
    w[3] = (9 * t3 - 9 * t2 + 2 * t) >>> 1;
    xq = 0;
    yq = 0;
    for (i = 0; i < 4; i++) begin
      xq += w[i] * longint'(g.px[i]);
      yq += w[i] * longint'(g.py[i]);
    end
  endfunction

  // Integer part toward zero, saturated to the signed pixel range.
  function automatic logic [ccsm_pkg::PIXW-1:0] to_pixel(longint vq);
    longint q;
    q = vq / (longint'(1) << ccsm_pkg::FRAC);
    if (q > 2047) q = 2047;
    if (q < -2048) q = -2048;
    return ccsm_pkg::PIXW'(q);
  endfunction

  class curve_mask_scoreboard;
    logic [ccsm_pkg::RADW-1:0] radius;
    pixel_t                    expected_pixels[$];
    int                        errors;

    function new();
      radius = ccsm_pkg::RADIUS_RST;
      errors = 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_sample(curve_item_t it);
      longint xq, yq, dx, dy, dist2, r2, far_lim;
      pixel_t p;
      bit     is_far;
      curve_point(it.k, it.g, xq, yq);
      dx = xq - (longint'(it.g.cx) << ccsm_pkg::FRAC);
      dy = yq - (longint'(it.g.cy) << ccsm_pkg::FRAC);
      far_lim = longint'(1) << ccsm_pkg::FAR_SH;
      is_far = (dx > far_lim) || (dx < -far_lim) || (dy > far_lim) || (dy < -far_lim);
      p.x = to_pixel(xq);
      p.y = to_pixel(yq);
      if (is_far) begin
        p.in_circle = 1'b0;
      end else begin
        dist2 = dx * dx + dy * dy;
        r2 = (longint'(radius) << ccsm_pkg::FRAC) * (longint'(radius) << ccsm_pkg::FRAC);
        // A point exactly on the circle produces no beat.
        if (dist2 == r2) return;
        p.in_circle = (dist2 < r2);
      end
      expected_pixels.push_back(p);
    endfunction

    function void check_pixel(logic [ccsm_pkg::PIXW-1:0] x, logic [ccsm_pkg::PIXW-1:0] y,
                              logic in_c);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result beat: pixel_x %0d pixel_y %0d inside_res %0d",
               $signed(x), $signed(y), in_c);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (x !== e.x) begin
        $error("pixel_x: expected %0d, actual %0d", $signed(e.x), $signed(x));
        errors++;
      end
      if (y !== e.y) begin
        $error("pixel_y: expected %0d, actual %0d", $signed(e.y), $signed(y));
        errors++;
      end
      if (in_c !== e.in_circle) begin
        $error("inside_res: expected %0d, actual %0d", e.in_circle, in_c);
        errors++;
      end
    endfunction
  endclass

  curve_mask_scoreboard sb = new();

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_pixel(out_pixel_x, out_pixel_y, out_inside_res);
  end

  // Ends the run when neither side has moved a beat for too long.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall = 0;
      else stall++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic curve_item_t make_item(int k, int x0, int y0, int x1, int y1,
                                            int x2, int y2, int x3, int y3,
                                            int cx, int cy);
    curve_item_t it;
    it.k = ccsm_pkg::KW'(k);
    it.g.px[0] = ccsm_pkg::CW'(x0);
    it.g.py[0] = ccsm_pkg::CW'(y0);
    it.g.px[1] = ccsm_pkg::CW'(x1);
    it.g.py[1] = ccsm_pkg::CW'(y1);
    it.g.px[2] = ccsm_pkg::CW'(x2);
    it.g.py[2] = ccsm_pkg::CW'(y2);
    it.g.px[3] = ccsm_pkg::CW'(x3);
    it.g.py[3] = ccsm_pkg::CW'(y3);
    it.g.cx = ccsm_pkg::CW'(cx);
    it.g.cy = ccsm_pkg::CW'(cy);
    return it;
  endfunction

  function automatic logic [ccsm_pkg::CW-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return ccsm_pkg::CW'(COORD_MAX);
    return ccsm_pkg::CW'(v);
  endfunction

  // Mostly random curves; about half get a center placed near the curve point so
  // that both colors show up, and a few are built to land exactly on the circle.
  function automatic curve_item_t random_item(logic [ccsm_pkg::RADW-1:0] r);
    curve_item_t it;
    longint xq, yq;
    int mode, ri, sel, ox, oy, i;
    ri = int'(r);
    it.k = ccsm_pkg::KW'($urandom_range(0, (1 << ccsm_pkg::KW) - 1));
    for (i = 0; i < 4; i++) begin
      it.g.px[i] = ccsm_pkg::CW'($urandom);
      it.g.py[i] = ccsm_pkg::CW'($urandom);
    end
    it.g.cx = ccsm_pkg::CW'($urandom);
    it.g.cy = ccsm_pkg::CW'($urandom);
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      // At k = 0 the curve sits on P0 and at k = SAMPLES on P3, both exactly.
      it.k = $urandom_range(0, 1) ? ccsm_pkg::KW'(ccsm_pkg::SAMPLES_DEF) : '0;
      sel = $urandom_range(0, 5);
      if (sel >= 4 && (ri % 5) != 0) sel -= 4;
      case (sel)
        0: begin ox = ri;           oy = 0;           end
        1: begin ox = -ri;          oy = 0;           end
        2: begin ox = 0;            oy = ri;          end
        3: begin ox = 0;            oy = -ri;         end
        4: begin ox = 3 * ri / 5;   oy = 4 * ri / 5;  end
        default: begin ox = -4 * ri / 5; oy = 3 * ri / 5; end
      endcase
      it.g.cx = ccsm_pkg::CW'($urandom_range(ri, COORD_MAX - ri));
      it.g.cy = ccsm_pkg::CW'($urandom_range(ri, COORD_MAX - ri));
      if (it.k == 0) begin
        it.g.px[0] = ccsm_pkg::CW'(int'(it.g.cx) + ox);
        it.g.py[0] = ccsm_pkg::CW'(int'(it.g.cy) + oy);
      end else begin
        it.g.px[3] = ccsm_pkg::CW'(int'(it.g.cx) + ox);
        it.g.py[3] = ccsm_pkg::CW'(int'(it.g.cy) + oy);
      end
    end else if (mode < 60) begin
      curve_point(it.k, it.g, xq, yq);
      it.g.cx = clamp_coord((xq >>> ccsm_pkg::FRAC)
                            + int'($urandom_range(0, 2 * ri + 16)) - (ri + 8));
      it.g.cy = clamp_coord((yq >>> ccsm_pkg::FRAC)
                            + int'($urandom_range(0, 2 * ri + 16)) - (ri + 8));
    end
    return it;
  endfunction

  task automatic send_item(input curve_item_t it);
    start <= 1'b1;
    in_sample_index <= it.k;
    in_p0_x <= it.g.px[0];
    in_p0_y <= it.g.py[0];
    in_p1_x <= it.g.px[1];
    in_p1_y <= it.g.py[1];
    in_p2_x <= it.g.px[2];
    in_p2_y <= it.g.py[2];
    in_p3_x <= it.g.px[3];
    in_p3_y <= it.g.py[3];
    in_center_x <= it.g.cx;
    in_center_y <= it.g.cy;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(it);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits for every expected beat, then lets any on-circle items leave the pipeline.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radius(input logic [ccsm_pkg::RADW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.radius = v;
  endtask

  initial begin
    curve_item_t directed[$];
    logic [ccsm_pkg::RADW-1:0] phase_radius[NUM_PHASES];
    int idle_pct, p, n;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats run with the radius left at its reset value of 60.
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023,
                                 1023, 1023));
    directed.push_back(make_item(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 0, 0));
    directed.push_back(make_item(1000, 0, 0, 0, 0, 0, 0, 1023, 1023, 1023, 1023));
    directed.push_back(make_item(999, 100, 900, 300, 700, 500, 500, 700, 300, 700, 300));
    directed.push_back(make_item(1001, 100, 900, 300, 700, 500, 500, 700, 300, 700, 300));
    directed.push_back(make_item(1, 10, 20, 800, 900, 30, 40, 1000, 5, 10, 20));
    directed.push_back(make_item(500, 0, 1023, 1023, 0, 0, 1023, 1023, 0, 512, 512));
    directed.push_back(make_item(333, 0, 0, 300, 600, 600, 300, 900, 900, 300, 600));
    // Far outside: extrapolated past P3 with the center in the opposite corner.
    directed.push_back(make_item(1023, 0, 0, 0, 0, 0, 0, 1023, 1023, 0, 0));
    // Extrapolation past the end pulls a P2-only curve below zero.
    directed.push_back(make_item(1023, 0, 0, 0, 0, 1023, 1023, 0, 0, 0, 0));
    directed.push_back(make_item(1023, 1023, 0, 0, 1023, 1023, 0, 0, 1023, 0, 1023));
    // Exactly on the circle, axis-aligned and on a 3-4-5 triangle: no beat.
    directed.push_back(make_item(0, 560, 500, 7, 8, 9, 10, 11, 12, 500, 500));
    directed.push_back(make_item(1000, 1, 2, 3, 4, 5, 6, 536, 548, 500, 500));
    directed.push_back(make_item(0, 559, 500, 7, 8, 9, 10, 11, 12, 500, 500));
    directed.push_back(make_item(0, 561, 500, 7, 8, 9, 10, 11, 12, 500, 500));
    directed.push_back(make_item(1000, 1, 2, 3, 4, 5, 6, 464, 452, 500, 500));
    directed.push_back(make_item(0, 1023, 1023, 0, 0, 0, 0, 0, 0, 1023, 1023));
    foreach (directed[i]) begin
      send_item(directed[i]);
      if (i == 8) hold_off(5);
    end

    phase_radius[0] = '0;
    phase_radius[1] = ccsm_pkg::RADW'((1 << ccsm_pkg::RADW) - 1);
    phase_radius[2] = ccsm_pkg::RADW'($urandom);
    phase_radius[3] = ccsm_pkg::RADW'(5 * $urandom_range(1, 102));
    phase_radius[4] = ccsm_pkg::RADW'(60);
    phase_radius[5] = ccsm_pkg::RADW'($urandom_range(1, 200));

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      write_radius(phase_radius[p]);
      // The third and the last phase stream back to back; the others mix gaps in.
      case (p % 3)
        0: idle_pct = 25;
        1: idle_pct = 8;
        default: idle_pct = 0;
      endcase
      if (p == NUM_PHASES - 1) idle_pct = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(phase_radius[p]));
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 19));
      end
    end

    drain_pipeline();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
